/* src/rrts_pkg.sv */
// shared types and constants of the round-robin time slicer
`timescale 1ns / 1ps

package rrts_pkg;

   localparam int MAX_JOBS  = 32;
   localparam int DUR_BITS  = 16;
   localparam int IDX_BITS  = (MAX_JOBS > 2) ? $clog2(MAX_JOBS) : 1;
   localparam int FILL_BITS = $clog2(MAX_JOBS + 1);
   localparam int SUM_BITS  = FILL_BITS + 1;

   typedef logic [IDX_BITS-1:0]  idx_type;
   typedef logic [DUR_BITS-1:0]  dur_type;
   typedef logic [FILL_BITS-1:0] fill_type;
   typedef logic [SUM_BITS-1:0]  sum_type;

   // one queued job: its index and the ticks it still needs
   typedef struct packed {
      idx_type job;
      dur_type rem;
   } entry_type;

   // where a cell loads its next entry from
   typedef enum logic [1:0] {
      SEL_KEEP    = 2'd0,
      SEL_NEIGH   = 2'd1,
      SEL_ARRIVAL = 2'd2,
      SEL_HELD    = 2'd3
   } sel_type;

endpackage

/* src/rrts_cell.sv */
// one queue position of the shifting ready queue
`timescale 1ns / 1ps

module rrts_cell (
   input  logic               clock,
   input  logic               en,
   input  rrts_pkg::sel_type   sel,
   input  rrts_pkg::entry_type neigh,
   input  rrts_pkg::entry_type arrival,
   input  rrts_pkg::entry_type held,
   output rrts_pkg::entry_type entry
);
   import rrts_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   always_comb begin
      unique case (sel)
         SEL_KEEP:    entry_in = entry_ff;
         SEL_NEIGH:   entry_in = neigh;
         SEL_ARRIVAL: entry_in = arrival;
         SEL_HELD:    entry_in = held;
         default:     entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;

endmodule

/* src/round_robin_time_slicer_top.sv */
// round-robin scheduler, one-tick slice, built as a shifting chain of queue cells
`timescale 1ns / 1ps
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  req     | req_valid/ready, arrive_valid, duration | in, one word per time slot
//  rsp     | rsp_valid/ready, run_*, job_done, arr_* | out, one word per slot
//
//  one slot per clock unless rsp stalls: a word is taken in the same cycle its
//  slot is worked, and the result lands in the rsp register the next cycle
//  the queue head sits in cell 0; each slot the chain shifts one step toward it
//  while the arrival and the held job are written behind the last valid cell
//  reset (synchronous) empties the queue, clears the index counter and held job
//  a stalled rsp holds req_ready low only while its register is full and not taken

module round_robin_time_slicer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_arrive_valid,
   input  logic [15:0] req_arrive_duration,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_run_valid,
   output logic [4:0]  rsp_run_job,
   output logic        rsp_job_done,
   output logic [4:0]  rsp_arrive_index,
   output logic        rsp_arrive_rejected
);
   import rrts_pkg::*;

   // control state
   fill_type  fill_ff, fill_in;
   sum_type   next_idx_ff, next_idx_in;
   logic      held_valid_ff, held_valid_in;
   entry_type held_ff, held_in;

   // output register
   logic      rsp_valid_ff, rsp_valid_in;
   logic      run_valid_ff, run_valid_in;
   logic [4:0] run_job_ff, run_job_in;
   logic      done_ff, done_in;
   logic [4:0] arr_idx_ff, arr_idx_in;
   logic      arr_rej_ff, arr_rej_in;

   logic      en;
   dur_type   dur;
   logic      arr_ok;
   entry_type arr_entry;
   sum_type   fill_ext;
   sum_type   held_pos;
   sum_type   total;
   logic      pop;
   entry_type head;

   entry_type cell_q [MAX_JOBS];
   sel_type   cell_sel [MAX_JOBS];

   // next word may enter while the result register empties in the same cycle
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign en        = req_valid && req_ready;

   // arrival check: nonzero duration and an unused index left
   assign dur       = dur_type'(req_arrive_duration);
   assign arr_ok    = req_arrive_valid && (dur != '0)
                      && (next_idx_ff < SUM_BITS'(MAX_JOBS));
   assign arr_entry = '{job: IDX_BITS'(next_idx_ff), rem: dur};

   // combined list this slot: queue cells, then arrival, then held job
   assign fill_ext = SUM_BITS'(fill_ff);
   assign held_pos = fill_ext + SUM_BITS'(arr_ok);
   assign total    = held_pos + SUM_BITS'(held_valid_ff);
   assign pop      = (total != '0);

   // entry that runs this slot
   always_comb begin
      if (fill_ff != '0) begin
         head = cell_q[0];
      end else if (arr_ok) begin
         head = arr_entry;
      end else begin
         head = held_ff;
      end
   end

   // chain of queue cells, cell 0 is the head
   for (genvar gi = 0; gi < MAX_JOBS; gi++) begin : g_cell
      sum_type   pos;
      entry_type neigh;

      // position in the combined list this cell takes after the shift
      assign pos = SUM_BITS'(gi) + SUM_BITS'(pop);

      if (gi == MAX_JOBS - 1) begin : g_last
         assign neigh = '0;
      end else begin : g_mid
         assign neigh = cell_q[gi+1];
      end

      always_comb begin
         if (pos < fill_ext) begin
            cell_sel[gi] = pop ? SEL_NEIGH : SEL_KEEP;
         end else if (arr_ok && (pos == fill_ext)) begin
            cell_sel[gi] = SEL_ARRIVAL;
         end else if (held_valid_ff && (pos == held_pos)) begin
            cell_sel[gi] = SEL_HELD;
         end else begin
            cell_sel[gi] = SEL_KEEP;
         end
      end

      rrts_cell u_cell (
         .clock   (clock),
         .en      (en),
         .sel     (cell_sel[gi]),
         .neigh   (neigh),
         .arrival (arr_entry),
         .held    (held_ff),
         .entry   (cell_q[gi])
      );
   end

   // slot bookkeeping and result word
   always_comb begin
      fill_in       = FILL_BITS'(total - SUM_BITS'(pop));
      next_idx_in   = next_idx_ff + SUM_BITS'(arr_ok);
      held_valid_in = 1'b0;
      held_in       = held_ff;
      run_valid_in  = pop;
      run_job_in    = 5'd0;
      done_in       = 1'b0;
      arr_idx_in    = arr_ok ? 5'(next_idx_ff) : 5'd0;
      arr_rej_in    = req_arrive_valid && !arr_ok;

      if (pop) begin
         run_job_in = 5'(head.job);
         // more than one tick left: preempt and requeue next slot
         if (head.rem > dur_type'(1)) begin
            held_valid_in = 1'b1;
            held_in       = '{job: head.job, rem: head.rem - dur_type'(1)};
         end else begin
            done_in = 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (en) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff       <= '0;
         next_idx_ff   <= '0;
         held_valid_ff <= 1'b0;
         held_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (en) begin
            fill_ff       <= fill_in;
            next_idx_ff   <= next_idx_in;
            held_valid_ff <= held_valid_in;
            held_ff       <= held_in;
         end
      end
   end

   // result payload, loaded with each accepted slot
   always_ff @(posedge clock) begin
      if (en) begin
         run_valid_ff <= run_valid_in;
         run_job_ff   <= run_job_in;
         done_ff      <= done_in;
         arr_idx_ff   <= arr_idx_in;
         arr_rej_ff   <= arr_rej_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_run_valid       = run_valid_ff;
   assign rsp_run_job         = run_job_ff;
   assign rsp_job_done        = done_ff;
   assign rsp_arrive_index    = arr_idx_ff;
   assign rsp_arrive_rejected = arr_rej_ff;

endmodule
